// File: rtl/sqw_pkg.sv
package sqw_pkg;

  localparam int unsigned FreqW   = 11;
  localparam int unsigned PeriodW = 14;

  localparam logic [FreqW-1:0] FREQ_MAX    = 11'h7FF;
  localparam logic [11:0]      PERIOD_BASE = 12'd2048;
  localparam logic [3:0]       VOLUME_MAX  = 4'd15;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_FRAME   = 2'd1,
    CMD_TRIGGER = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    REG_SWEEP      = 3'd0,
    REG_ENVELOPE   = 3'd1,
    REG_DUTY       = 3'd2,
    REG_START_FREQ = 3'd3,
    REG_LEN_LIMIT  = 3'd4,
    REG_LEN_EN     = 3'd5,
    REG_DAC_EN     = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [6:0]       sweep;
    logic [7:0]       envelope;
    logic [1:0]       duty;
    logic [FreqW-1:0] start_freq;
    logic [6:0]       len_limit;
    logic             length_en;
    logic             dac_en;
  } cfg_t;

  // one row per duty setting, bit n is position n
  localparam logic [7:0] DUTY_PATTERNS [4] = '{
    8'b1000_0000,
    8'b1000_0001,
    8'b1110_0001,
    8'b0111_1110
  };

  function automatic logic duty_bit(logic [1:0] sel, logic [2:0] pos);
    logic [7:0] row;
    row = DUTY_PATTERNS[sel];
    return row[pos];
  endfunction

  // next sweep frequency, one bit wider to show overflow on increase
  function automatic logic [FreqW:0] sweep_target(logic [FreqW-1:0] shadow,
                                                  logic [6:0] setting);
    logic [FreqW-1:0] delta;
    logic [FreqW:0]   res;
    delta = shadow >> setting[2:0];
    if (shadow == '0) begin
      res = '0;
    end else if (setting[3]) begin
      res = {1'b0, shadow} - {1'b0, delta};
    end else begin
      res = {1'b0, shadow} + {1'b0, delta};
    end
    return res;
  endfunction

  function automatic logic sweep_ovf(logic [FreqW:0] target, logic [6:0] setting);
    return !setting[3] && target[FreqW];
  endfunction

  function automatic logic [PeriodW-1:0] period_reload(logic [FreqW-1:0] freq);
    logic [11:0] diff;
    diff = PERIOD_BASE - {1'b0, freq};
    return {diff, 2'b00};
  endfunction

endpackage

// File: rtl/sqw_if.sv
interface sqw_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [2:0] step_num;

  modport source (output valid, output cmd, output step_num, input ready);
  modport sink (input valid, input cmd, input step_num, output ready);
endinterface

interface sqw_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  amplitude;
  logic        channel_on;
  logic [10:0] current_frequency;
  logic        frequency_written;

  modport source (output valid, output amplitude, output channel_on,
                  output current_frequency, output frequency_written, input ready);
  modport sink (input valid, input amplitude, input channel_on,
                input current_frequency, input frequency_written, output ready);
endinterface

// File: rtl/sqw_cfg.sv
module sqw_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output sqw_pkg::cfg_t cfg_o
);
  import sqw_pkg::*;

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SWEEP:      cfg_d.sweep      = pwdata[6:0];
        REG_ENVELOPE:   cfg_d.envelope   = pwdata[7:0];
        REG_DUTY:       cfg_d.duty       = pwdata[1:0];
        REG_START_FREQ: cfg_d.start_freq = pwdata[FreqW-1:0];
        REG_LEN_LIMIT:  cfg_d.len_limit  = pwdata[6:0];
        REG_LEN_EN:     cfg_d.length_en  = pwdata[0];
        REG_DAC_EN:     cfg_d.dac_en     = pwdata[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SWEEP:      prdata = {25'd0, cfg_q.sweep};
      REG_ENVELOPE:   prdata = {24'd0, cfg_q.envelope};
      REG_DUTY:       prdata = {30'd0, cfg_q.duty};
      REG_START_FREQ: prdata = {21'd0, cfg_q.start_freq};
      REG_LEN_LIMIT:  prdata = {25'd0, cfg_q.len_limit};
      REG_LEN_EN:     prdata = {31'd0, cfg_q.length_en};
      REG_DAC_EN:     prdata = {31'd0, cfg_q.dac_en};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/square_wave_channel_with_sweep.sv
// Square channel with envelope, length counter and frequency sweep.
// The result is registered at the edge that accepts the command transaction.
// Throughput: one command per cycle; the channel state and the result
// register both update at the accepting edge, so ready only drops when a
// result is held back by the consumer.
// Reset: all channel state, configuration and the result valid clear to 0.
module square_wave_channel_with_sweep (
  input  logic        clk_i,
  input  logic        rst_ni,
  sqw_in_if.sink      in_i,
  sqw_out_if.source   res_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sqw_pkg::*;

  localparam logic [2:0] STEP_ENV     = 3'd7;
  localparam logic [2:0] STEP_SWEEP_A = 3'd2;
  localparam logic [2:0] STEP_SWEEP_B = 3'd6;

  typedef struct packed {
    logic [3:0]       amplitude;
    logic             channel_on;
    logic [FreqW-1:0] current_frequency;
    logic             frequency_written;
  } res_t;

  cfg_t cfg;

  logic               playing_q, playing_d;
  logic [PeriodW-1:0] period_q, period_d;
  logic [2:0]         duty_pos_q, duty_pos_d;
  logic [3:0]         volume_q, volume_d;
  logic [2:0]         env_cnt_q, env_cnt_d;
  logic [3:0]         lat_env_q, lat_env_d;
  logic [1:0]         lat_duty_q, lat_duty_d;
  logic [2:0]         sw_pace_q, sw_pace_d;
  logic [2:0]         sweep_cnt_q, sweep_cnt_d;
  logic [FreqW-1:0]   shadow_q, shadow_d;
  logic [FreqW-1:0]   freq_q, freq_d;
  logic [6:0]         len_cnt_q, len_cnt_d;
  logic               wrote_d;

  logic               out_valid_q;
  res_t               res_q, res_d;
  logic               in_acc;

  logic [FreqW:0]     trig_target, sweep_tgt, sweep_tgt2;
  logic [PeriodW-1:0] period_dec;
  logic [6:0]         len_inc;

  sqw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_i.ready = !out_valid_q || res_o.ready;
  assign in_acc     = in_i.valid && in_i.ready;

  assign trig_target = sweep_target(cfg.start_freq, cfg.sweep);
  assign sweep_tgt   = sweep_target(shadow_q, cfg.sweep);
  assign sweep_tgt2  = sweep_target(sweep_tgt[FreqW-1:0], cfg.sweep);
  assign period_dec  = period_q - PeriodW'(1);
  assign len_inc     = len_cnt_q + 7'd1;

  always_comb begin
    playing_d   = playing_q;
    period_d    = period_q;
    duty_pos_d  = duty_pos_q;
    volume_d    = volume_q;
    env_cnt_d   = env_cnt_q;
    lat_env_d   = lat_env_q;
    lat_duty_d  = lat_duty_q;
    sw_pace_d   = sw_pace_q;
    sweep_cnt_d = sweep_cnt_q;
    shadow_d    = shadow_q;
    freq_d      = freq_q;
    len_cnt_d   = len_cnt_q;
    wrote_d     = 1'b0;

    case (in_i.cmd)
      CMD_TICK: begin
        if (playing_q) begin
          if (period_dec == '0) begin
            period_d   = period_reload(freq_q);
            duty_pos_d = duty_pos_q + 3'd1;
          end else begin
            period_d = period_dec;
          end
        end
      end
      CMD_FRAME: begin
        if (!in_i.step_num[0] && cfg.length_en) begin
          if (len_inc >= cfg.len_limit) begin
            playing_d = 1'b0;
            len_cnt_d = '0;
          end else begin
            len_cnt_d = len_inc;
          end
        end
        if (in_i.step_num == STEP_ENV && lat_env_q[2:0] != '0) begin
          if (env_cnt_q + 3'd1 >= lat_env_q[2:0]) begin
            env_cnt_d = '0;
            if (lat_env_q[3] && volume_q < VOLUME_MAX) begin
              volume_d = volume_q + 4'd1;
            end else if (!lat_env_q[3] && volume_q != '0) begin
              volume_d = volume_q - 4'd1;
            end
          end else begin
            env_cnt_d = env_cnt_q + 3'd1;
          end
        end
        if ((in_i.step_num == STEP_SWEEP_A || in_i.step_num == STEP_SWEEP_B)
            && sw_pace_q != '0) begin
          if (sweep_cnt_q + 3'd1 >= sw_pace_q) begin
            sw_pace_d   = cfg.sweep[6:4];
            sweep_cnt_d = '0;
            if (sweep_ovf(sweep_tgt, cfg.sweep)) begin
              playing_d = 1'b0;
            end else if (cfg.sweep[2:0] != '0) begin
              freq_d   = sweep_tgt[FreqW-1:0];
              shadow_d = sweep_tgt[FreqW-1:0];
              wrote_d  = 1'b1;
              // recheck with the written value
              if (sweep_ovf(sweep_tgt2, cfg.sweep)) begin
                playing_d = 1'b0;
              end
            end
          end else begin
            sweep_cnt_d = sweep_cnt_q + 3'd1;
          end
        end
      end
      CMD_TRIGGER: begin
        env_cnt_d = '0;
        if (len_cnt_q >= cfg.len_limit) begin
          len_cnt_d = '0;
        end
        volume_d     = cfg.envelope[7:4];
        if (cfg.dac_en) begin
          playing_d = 1'b1;
        end
        lat_duty_d   = cfg.duty;
        lat_env_d    = cfg.envelope[3:0];
        freq_d       = cfg.start_freq;
        period_d     = period_reload(cfg.start_freq);
        sw_pace_d    = cfg.sweep[6:4];
        shadow_d     = cfg.start_freq;
        sweep_cnt_d  = '0;
        if (cfg.sweep[2:0] != '0 && sweep_ovf(trig_target, cfg.sweep)) begin
          playing_d = 1'b0;
        end
      end
      default: ;
    endcase

    res_d.amplitude         = duty_bit(lat_duty_d, duty_pos_d) ? volume_d : 4'd0;
    res_d.channel_on        = playing_d;
    res_d.current_frequency = freq_d;
    res_d.frequency_written = wrote_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      playing_q   <= 1'b0;
      period_q    <= '0;
      duty_pos_q  <= '0;
      volume_q    <= '0;
      env_cnt_q   <= '0;
      lat_env_q   <= '0;
      lat_duty_q  <= '0;
      sw_pace_q   <= '0;
      sweep_cnt_q <= '0;
      shadow_q    <= '0;
      freq_q      <= '0;
      len_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        playing_q   <= playing_d;
        period_q    <= period_d;
        duty_pos_q  <= duty_pos_d;
        volume_q    <= volume_d;
        env_cnt_q   <= env_cnt_d;
        lat_env_q   <= lat_env_d;
        lat_duty_q  <= lat_duty_d;
        sw_pace_q   <= sw_pace_d;
        sweep_cnt_q <= sweep_cnt_d;
        shadow_q    <= shadow_d;
        freq_q      <= freq_d;
        len_cnt_q   <= len_cnt_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid             = out_valid_q;
  assign res_o.amplitude         = res_q.amplitude;
  assign res_o.channel_on        = res_q.channel_on;
  assign res_o.current_frequency = res_q.current_frequency;
  assign res_o.frequency_written = res_q.frequency_written;

  a_acc_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> out_valid_q)
    else $error("accepted command produced no result");

  a_tick_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.cmd == CMD_TICK && !playing_q |=> $stable(period_q) && $stable(duty_pos_q))
    else $error("period tick advanced a stopped channel");

  a_write_syncs_shadow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && wrote_d |=> freq_q == shadow_q && res_q.current_frequency == freq_q)
    else $error("sweep write left shadow and live frequency apart");

  a_trigger_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.cmd == CMD_TRIGGER |=> sweep_cnt_q == '0 && env_cnt_q == '0)
    else $error("trigger did not restart sweep and envelope counters");

endmodule
